@@ rtl/core/red_run_bearing_tracker_unit_defines.svh @@
// assertion macros for the run bearing tracker
`ifndef RED_RUN_BEARING_TRACKER_UNIT_DEFINES_SVH
`define RED_RUN_BEARING_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication
`define RRBT_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrbt assertion failed");

// next-cycle implication
`define RRBT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrbt assertion failed");

`endif

@@ rtl/core/rrbt_pkg.sv @@
// types, constants and the arctangent table of the run bearing tracker
package rrbt_pkg;

  localparam int DEF_LINE_PIXELS  = 128;
  localparam int DEF_CORDIC_STEPS = 16;
  localparam int FRAC_SHIFT       = 24;
  localparam int ATAN_LEN         = 24;
  localparam int STEP_W           = 5;
  localparam int ANG_W            = 18;
  localparam int MID_W            = 14;
  localparam int QUEUE_DEPTH      = 2;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL        = 2'd2;

  localparam logic [7:0] RST_TARGET_LEVEL = 8'd255;
  localparam logic [7:0] RST_CENTRE       = 8'd127;
  localparam logic [9:0] RST_FOCAL        = 10'd128;

  typedef struct packed {
    logic [7:0]         red_value;
    logic               line_last;
    logic signed [15:0] eye_angle;
    logic               eye_tag;
  } red_in_t;

  typedef struct packed {
    logic signed [15:0] setpoint_angle;
    logic               target_seen;
    logic [8:0]         midpoint_half_pixels;
    logic               eye_out;
  } red_out_t;

  typedef struct packed {
    logic               seen;
    logic [MID_W-1:0]   mid;
    logic signed [15:0] eye;
    logic               tag;
  } rrbt_job_t;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_RUN,
    PH_DONE
  } scan_phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_FIN
  } back_state_t;

  function automatic logic [15:0] atan_q16(input logic [STEP_W-1:0] i);
    logic [15:0] v;
    unique case (i)
      5'd0:    v = 16'd51472;
      5'd1:    v = 16'd30386;
      5'd2:    v = 16'd16055;
      5'd3:    v = 16'd8150;
      5'd4:    v = 16'd4091;
      5'd5:    v = 16'd2047;
      5'd6:    v = 16'd1024;
      5'd7:    v = 16'd512;
      5'd8:    v = 16'd256;
      5'd9:    v = 16'd128;
      5'd10:   v = 16'd64;
      5'd11:   v = 16'd32;
      5'd12:   v = 16'd16;
      5'd13:   v = 16'd8;
      5'd14:   v = 16'd4;
      5'd15:   v = 16'd2;
      5'd16:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/rrbt_front.sv @@
// pixel scan front end: finds the first target run and emits one job per line
module rrbt_front #(
  parameter int LINE_PIXELS = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               beat,
  input  rrbt_pkg::red_in_t  pix,
  input  logic [7:0]         target_level,
  output logic               push,
  output rrbt_pkg::rrbt_job_t job
);
  import rrbt_pkg::*;

  localparam int PIX_W = $clog2(LINE_PIXELS + 1);
  localparam int IDX_W = $clog2(LINE_PIXELS);

  scan_phase_t      phase_r, phase_nxt, phase_upd;
  logic [IDX_W-1:0] start_r, start_nxt, start_upd;
  logic [IDX_W-1:0] end_r, end_nxt, end_upd;
  logic [PIX_W-1:0] index_r, index_nxt, index_upd;
  logic             active;
  logic             hit;
  logic [IDX_W-1:0] idx_cur;

  assign active  = index_r < PIX_W'(LINE_PIXELS);
  assign hit     = pix.red_value == target_level;
  assign idx_cur = index_r[IDX_W-1:0];

  // next state
  always_comb begin
    phase_upd = phase_r;
    if (active) begin
      unique case (phase_r)
        PH_SEARCH: if (hit) phase_upd = PH_RUN;
        PH_RUN:    if (!hit) phase_upd = PH_DONE;
        PH_DONE:   phase_upd = PH_DONE;
        default:   phase_upd = PH_SEARCH;
      endcase
    end
    phase_nxt = phase_r;
    if (beat) begin
      phase_nxt = pix.line_last ? PH_SEARCH : phase_upd;
    end
  end

  // outputs and datapath
  always_comb begin
    start_upd = start_r;
    end_upd   = end_r;
    index_upd = index_r;
    if (active) begin
      index_upd = index_r + PIX_W'(1);
      if (phase_r == PH_SEARCH && hit) begin
        start_upd = idx_cur;
        end_upd   = idx_cur;
      end else if (phase_r == PH_RUN && hit) begin
        end_upd = idx_cur;
      end
    end
    start_nxt = start_r;
    end_nxt   = end_r;
    index_nxt = index_r;
    if (beat) begin
      start_nxt = pix.line_last ? '0 : start_upd;
      end_nxt   = pix.line_last ? '0 : end_upd;
      index_nxt = pix.line_last ? '0 : index_upd;
    end
    push     = beat && pix.line_last;
    job.seen = phase_upd != PH_SEARCH;
    job.mid  = job.seen ? MID_W'(start_upd) + MID_W'(end_upd) : MID_W'({index_upd, 1'b0});
    job.eye  = pix.eye_angle;
    job.tag  = pix.eye_tag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      start_r <= '0;
      end_r   <= '0;
      index_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      start_r <= start_nxt;
      end_r   <= end_nxt;
      index_r <= index_nxt;
    end
  end

endmodule

@@ rtl/core/rrbt_queue.sv @@
// short job queue between the scan front end and the bearing back end
`include "red_run_bearing_tracker_unit_defines.svh"

module rrbt_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rrbt_pkg::rrbt_job_t push_job,
  input  logic                pop,
  output logic                q_valid,
  output rrbt_pkg::rrbt_job_t q_job,
  output logic                full
);
  import rrbt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rrbt_job_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_valid = count_r != '0;
  assign full    = count_r == CNT_W'(QUEUE_DEPTH);
  assign q_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `RRBT_ASSERT(a_no_overflow, push, !full)
  `RRBT_ASSERT(a_no_underflow, pop, q_valid)
  `RRBT_ASSERT_NEXT(a_count_moves, push && !pop, count_r != $past(count_r))

endmodule

@@ rtl/core/rrbt_back.sv @@
// bearing back end: iterative vectoring cordic, rounding, saturation and result register
`include "red_run_bearing_tracker_unit_defines.svh"

module rrbt_back #(
  parameter int LINE_PIXELS  = 128,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  rrbt_pkg::rrbt_job_t q_job,
  output logic                pop,
  input  logic [7:0]          centre,
  input  logic [9:0]          focal,
  output logic                out_valid,
  input  logic                out_stall,
  output rrbt_pkg::red_out_t  out_data
);
  import rrbt_pkg::*;

  localparam int STEPS_EFF = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int CW        = $clog2(2 * LINE_PIXELS + 256) + 3 + FRAC_SHIFT;
  localparam int D_W       = MID_W + 1;
  localparam logic signed [ANG_W:0] SP_MAX = 32767;
  localparam logic signed [ANG_W:0] SP_MIN = -32768;
  localparam logic signed [ANG_W:0] RND    = 4;

  back_state_t              state_r, state_nxt;
  logic [STEP_W-1:0]        step_r;
  logic signed [CW-1:0]     x_r, y_r;
  logic signed [ANG_W-1:0]  ang_r;
  rrbt_job_t                job_r;
  logic                     out_valid_r;
  red_out_t                 out_data_r;

  logic                     slot_free;
  logic                     load;
  logic                     step_last;
  logic signed [D_W-1:0]    diff;
  logic signed [CW-1:0]     x_init, y_init;
  logic signed [CW-1:0]     xs, ys;
  logic signed [ANG_W-1:0]  atan_step;
  logic                     y_pos;
  logic signed [ANG_W:0]    z_rnd, z_q13, sp_sum;
  logic signed [15:0]       sp_sat;

  assign slot_free = !out_valid_r || !out_stall;
  assign step_last = step_r == STEP_W'(STEPS_EFF - 1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (q_valid) state_nxt = q_job.seen ? BK_RUN : BK_FIN;
      BK_RUN:  if (step_last) state_nxt = BK_FIN;
      BK_FIN:  if (slot_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop  = (state_r == BK_IDLE) && q_valid;
    load = (state_r == BK_FIN) && slot_free;
  end

  // cordic datapath
  always_comb begin
    diff      = signed'(D_W'(q_job.mid)) - signed'(D_W'(centre));
    x_init    = signed'(CW'(focal)) <<< FRAC_SHIFT;
    y_init    = CW'(diff) <<< FRAC_SHIFT;
    xs        = x_r >>> step_r;
    ys        = y_r >>> step_r;
    atan_step = signed'(ANG_W'(atan_q16(step_r)));
    y_pos     = !y_r[CW-1] && (y_r != '0);
    z_rnd     = (ANG_W+1)'(ang_r) + RND;
    z_q13     = z_rnd >>> 3;
    sp_sum    = z_q13 + (ANG_W+1)'(job_r.eye);
    if (sp_sum > SP_MAX) begin
      sp_sat = 16'sd32767;
    end else if (sp_sum < SP_MIN) begin
      sp_sat = -16'sd32768;
    end else begin
      sp_sat = sp_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r  <= q_job;
      x_r    <= x_init;
      y_r    <= y_init;
      ang_r  <= '0;
      step_r <= '0;
    end else if (state_r == BK_RUN) begin
      if (y_pos) begin
        x_r   <= x_r + ys;
        y_r   <= y_r - xs;
        ang_r <= ang_r + atan_step;
      end else begin
        x_r   <= x_r - ys;
        y_r   <= y_r + xs;
        ang_r <= ang_r - atan_step;
      end
      step_r <= step_r + STEP_W'(1);
    end
    if (load) begin
      out_data_r.setpoint_angle       <= job_r.seen ? sp_sat : '0;
      out_data_r.target_seen          <= job_r.seen;
      out_data_r.midpoint_half_pixels <= job_r.mid[8:0];
      out_data_r.eye_out              <= job_r.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RRBT_ASSERT(a_step_bound, state_r == BK_RUN, step_r < STEP_W'(STEPS_EFF))
  `RRBT_ASSERT(a_unseen_zero, out_valid_r && !out_data_r.target_seen, out_data_r.setpoint_angle == '0)
  `RRBT_ASSERT_NEXT(a_fin_loads, state_r == BK_FIN && !out_valid_r, out_valid_r && state_r == BK_IDLE)

endmodule

@@ rtl/core/red_run_bearing_tracker_unit.sv @@
// Run bearing tracker top level. Pixels are taken one per clock while the two-entry job
// queue has room; each line's last pixel queues one job. The back end fetches a job in
// BK_IDLE, runs min(CORDIC_STEPS, 24) iterative CORDIC steps in BK_RUN for a line with a
// target run (none without), and loads the result register in BK_FIN once the output slot
// is free; meanwhile the queue keeps taking pixels of later lines. Configuration
// writes are always ready and take effect on the next cycle.
module red_run_bearing_tracker_unit #(
  parameter int LINE_PIXELS  = rrbt_pkg::DEF_LINE_PIXELS,
  parameter int CORDIC_STEPS = rrbt_pkg::DEF_CORDIC_STEPS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  rrbt_pkg::red_in_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output rrbt_pkg::red_out_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rrbt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rrbt_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rrbt_pkg::*;

  logic [7:0] target_level_r;
  logic [7:0] centre_r;
  logic [9:0] focal_r;
  logic       beat;
  logic       push;
  rrbt_job_t  push_job;
  logic       pop;
  logic       q_valid;
  rrbt_job_t  q_job;
  logic       q_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign beat      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_level_r <= RST_TARGET_LEVEL;
      centre_r       <= RST_CENTRE;
      focal_r        <= RST_FOCAL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TARGET_LEVEL: target_level_r <= cfg_data[7:0];
        CFG_CENTRE:       centre_r       <= cfg_data[7:0];
        CFG_FOCAL:        focal_r        <= cfg_data[9:0];
        default:          ;
      endcase
    end
  end

  rrbt_front #(
    .LINE_PIXELS(LINE_PIXELS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat         (beat),
    .pix          (in_data),
    .target_level (target_level_r),
    .push         (push),
    .job          (push_job)
  );

  rrbt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .full     (q_full)
  );

  rrbt_back #(
    .LINE_PIXELS  (LINE_PIXELS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .centre    (centre_r),
    .focal     (focal_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ tb/red_run_bearing_tracker_unit_tb.sv @@
// self-checking testbench for the run bearing tracker: directed table, then random scan lines
module red_run_bearing_tracker_unit_tb;
  import rrbt_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 6;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 1050;
  localparam int PHASES         = 8;
  localparam int STEPS_USED     = (DEF_CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : DEF_CORDIC_STEPS;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam longint ATAN_STEP_Q16 [ATAN_LEN] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2,
    1, 0, 0, 0, 0, 0, 0, 0
  };

  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_value;
    red_in_t               pixel;
    logic                  typed;
    red_out_t              want;
  } directed_row_t;

  localparam int DIRECTED_LEN = 24;
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    '{ROW_PIXEL, CFG_TARGET_LEVEL, 10'd0, '{8'd0, 1'b1, 16'h0000, 1'b0}, 1'b1,
      '{16'h0000, 1'b0, 9'd2, 1'b0}},
    '{ROW_PIXEL, CFG_TARGET_LEVEL, 10'd0, '{8'd255, 1'b1, 16'h7FFF, 1'b1}, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_LEVEL, 10'd0, '{8'd255, 1'b1, 16'h8000, 1'b0}, 1'b1,
      '{16'h8000, 1'b1, 9'd0, 1'b0}},
    // second run in the line is ignored
    '{ROW_PIXEL, CFG_TARGET_LEVEL, 10'd0, '{8'd0, 1'b0, 16'h0000, 1'b1}, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_LEVEL, 10'd0, '{8'd255, 1'b0, 16'h0000, 1'b1}, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_LEVEL, 10'd0, '{8'd255, 1'b0, 16'h0000, 1'b1}, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_LEVEL, 10'd0, '{8'd0, 1'b0, 16'h0000, 1'b1}, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_LEVEL, 10'd0, '{8'd255, 1'b1, 16'h0000, 1'b1}, 1'b0, '0},
    // run still open at line end
    '{ROW_PIXEL, CFG_TARGET_LEVEL, 10'd0, '{8'd0, 1'b0, 16'h0000, 1'b0}, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_LEVEL, 10'd0, '{8'd255, 1'b1, 16'hFFFF, 1'b0}, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_LEVEL, 10'd0, '{8'd254, 1'b1, 16'hFFFF, 1'b1}, 1'b1,
      '{16'h0000, 1'b0, 9'd2, 1'b1}},
    '{ROW_WRITE, CFG_TARGET_LEVEL, 10'd0, '0, 1'b0, '0},
    '{ROW_WRITE, CFG_CENTRE, 10'd0, '0, 1'b0, '0},
    // zero offset
    '{ROW_PIXEL, CFG_TARGET_LEVEL, 10'd0, '{8'd0, 1'b1, 16'h0000, 1'b0}, 1'b0, '0},
    '{ROW_WRITE, CFG_FOCAL, 10'd0, '0, 1'b0, '0},
    // zero focal with zero offset
    '{ROW_PIXEL, CFG_TARGET_LEVEL, 10'd0, '{8'd0, 1'b1, 16'h0000, 1'b1}, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_LEVEL, 10'd0, '{8'd5, 1'b0, 16'h0000, 1'b0}, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_LEVEL, 10'd0, '{8'd0, 1'b0, 16'h0000, 1'b0}, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_LEVEL, 10'd0, '{8'd0, 1'b1, 16'h7FFF, 1'b1}, 1'b1,
      '{16'h7FFF, 1'b1, 9'd3, 1'b1}},
    '{ROW_WRITE, CFG_FOCAL, 10'd1023, '0, 1'b0, '0},
    '{ROW_WRITE, CFG_CENTRE, 10'd255, '0, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_LEVEL, 10'd0, '{8'd0, 1'b1, 16'h0000, 1'b1}, 1'b0, '0},
    '{ROW_WRITE, CFG_UNUSED, 10'h3FF, '0, 1'b0, '0},
    '{ROW_PIXEL, CFG_TARGET_LEVEL, 10'd0, '{8'd1, 1'b1, 16'h0000, 1'b0}, 1'b1,
      '{16'h0000, 1'b0, 9'd2, 1'b0}}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  red_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  red_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [7:0]  level_q;
  logic [7:0]  centre_q;
  logic [9:0]  focal_q;
  scan_phase_t phase_q;
  int          run_first;
  int          run_last;
  int          pix_count;
  red_out_t    pending_setpoints[$];
  bit          override_next;
  red_out_t    override_result;
  int          mismatches;
  int          burst_left;
  bit          sender_calm;
  logic [15:0] stall_pattern;
  logic [7:0]  stall_step;

  red_run_bearing_tracker_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  function automatic longint bearing_q16(input longint dy, input longint dx);
    longint cx;
    longint cy;
    longint acc;
    longint sx;
    longint sy;
    cx = dx * (longint'(1) <<< FRAC_SHIFT);
    cy = dy * (longint'(1) <<< FRAC_SHIFT);
    acc = 0;
    for (int i = 0; i < STEPS_USED; i++) begin
      sx = cx >>> i;
      sy = cy >>> i;
      if (cy > 0) begin
        cx += sy;
        cy -= sx;
        acc += ATAN_STEP_Q16[i];
      end else begin
        cx -= sy;
        cy += sx;
        acc -= ATAN_STEP_Q16[i];
      end
    end
    return acc;
  endfunction

  task automatic track_pixel(input red_in_t px);
    red_out_t res;
    bit       hit;
    bit       seen;
    int       mid;
    longint   setpoint;
    if (pix_count < DEF_LINE_PIXELS) begin
      hit = (px.red_value == level_q);
      if (phase_q == PH_SEARCH) begin
        if (hit) begin
          run_first = pix_count;
          run_last  = pix_count;
          phase_q   = PH_RUN;
        end
      end else if (phase_q == PH_RUN) begin
        if (hit) begin
          run_last = pix_count;
        end else begin
          phase_q = PH_DONE;
        end
      end
      pix_count++;
    end
    if (!px.line_last) return;
    seen = (phase_q != PH_SEARCH);
    mid = seen ? run_first + run_last : 2 * pix_count;
    setpoint = 0;
    if (seen) begin
      setpoint = bearing_q16(longint'(mid) - longint'(centre_q), longint'(focal_q));
      setpoint = ((setpoint + 4) >>> 3) + longint'($signed(px.eye_angle));
      if (setpoint > 32767) setpoint = 32767;
      if (setpoint < -32768) setpoint = -32768;
    end
    res.setpoint_angle       = setpoint[15:0];
    res.target_seen          = seen;
    res.midpoint_half_pixels = mid[8:0];
    res.eye_out              = px.eye_tag;
    if (override_next) res = override_result;
    pending_setpoints.push_back(res);
    phase_q   = PH_SEARCH;
    run_first = 0;
    run_last  = 0;
    pix_count = 0;
  endtask

  task automatic check_result(input red_out_t got);
    red_out_t want;
    if (pending_setpoints.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending, setpoint %0d midpoint %0d",
                                got.setpoint_angle, got.midpoint_half_pixels));
      return;
    end
    want = pending_setpoints.pop_front();
    if (got.setpoint_angle !== want.setpoint_angle)
      report_mismatch($sformatf("setpoint_angle got %0d expected %0d",
                                got.setpoint_angle, want.setpoint_angle));
    if (got.target_seen !== want.target_seen)
      report_mismatch($sformatf("target_seen got %0b expected %0b",
                                got.target_seen, want.target_seen));
    if (got.midpoint_half_pixels !== want.midpoint_half_pixels)
      report_mismatch($sformatf("midpoint_half_pixels got %0d expected %0d",
                                got.midpoint_half_pixels, want.midpoint_half_pixels));
    if (got.eye_out !== want.eye_out)
      report_mismatch($sformatf("eye_out got %0b expected %0b", got.eye_out, want.eye_out));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TARGET_LEVEL: level_q = cfg_data[7:0];
          CFG_CENTRE:       centre_q = cfg_data[7:0];
          CFG_FOCAL:        focal_q = cfg_data[9:0];
          default:          ;
        endcase
      end
      if (in_valid && !in_stall) track_pixel(in_data);
      if (out_valid && !out_stall) check_result(out_data);
    end
  end

  task automatic send_pixel(input red_in_t px, input bit typed, input red_out_t want);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!sender_calm) gap = $urandom_range(0, 8);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk) in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        = 1'b1;
    in_data         = px;
    override_next   = typed;
    override_result = want;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic hold_until_drained(input bit settle);
    @(negedge clk) in_valid = 1'b0;
    while (pending_setpoints.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    hold_until_drained(1'b1);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  // receiver stall pattern, reshuffled whenever the 8-bit step counter wraps
  initial begin
    out_stall     = 1'b0;
    stall_pattern = '0;
    stall_step    = '0;
    forever begin
      @(negedge clk);
      if (stall_step == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern = 16'h0000;
          1:       stall_pattern = 16'hFFFE;
          default: stall_pattern = 16'($urandom);
        endcase
      end
      out_stall = stall_pattern[stall_step[3:0]];
      stall_step++;
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[red_run_bearing_tracker_unit] ERROR");
    $finish;
  end

  initial begin
    red_in_t    px;
    logic [7:0] back;
    logic [7:0] red;
    logic [7:0] pick;
    logic [9:0] focal;
    int         len;
    int         shape;
    int         run_at;
    int         run_len;
    int         rerun_at;
    bit         rerun;
    int         items;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_TARGET_LEVEL;
    cfg_data      = '0;
    level_q       = RST_TARGET_LEVEL;
    centre_q      = RST_CENTRE;
    focal_q       = RST_FOCAL;
    phase_q       = PH_SEARCH;
    run_first     = 0;
    run_last      = 0;
    pix_count     = 0;
    override_next = 1'b0;
    mismatches    = 0;
    burst_left    = 0;
    sender_calm   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    for (int r = 0; r < DIRECTED_LEN; r++) begin
      if (DIRECTED_ROWS[r].kind == ROW_WRITE) begin
        write_register(DIRECTED_ROWS[r].reg_index, DIRECTED_ROWS[r].reg_value);
      end else begin
        send_pixel(DIRECTED_ROWS[r].pixel, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      sender_calm = (p % 3 == 2);
      pick = (p == 0) ? 8'd0 : (p == 1) ? 8'd255 : 8'($urandom);
      write_register(CFG_TARGET_LEVEL, {2'($urandom), pick});
      pick = (p == 0) ? 8'd0 : (p == 1) ? 8'd255 : (p == 5) ? 8'($urandom) :
             8'($urandom_range(0, 48));
      write_register(CFG_CENTRE, {2'($urandom), pick});
      focal = (p == 0) ? 10'd1 : (p == 1) ? 10'd1023 : (p == 3) ? 10'd0 :
              (p % 2 == 1) ? 10'($urandom_range(1, 64)) : 10'($urandom_range(1, 1023));
      write_register(CFG_FOCAL, focal);

      items = 0;
      while (items < RANDOM_ITEMS / PHASES) begin
        shape = $urandom_range(0, 99);
        if (shape < 2) begin
          len = $urandom_range(DEF_LINE_PIXELS + 1, DEF_LINE_PIXELS + 22);
        end else if (shape < 4) begin
          len = DEF_LINE_PIXELS;
        end else begin
          len = $urandom_range(1, 24);
        end
        // keep each phase within its share of the item budget
        if (len > RANDOM_ITEMS / PHASES - items) len = RANDOM_ITEMS / PHASES - items;
        shape    = $urandom_range(0, 9);
        run_at   = $urandom_range(0, len - 1);
        run_len  = $urandom_range(1, 8);
        rerun    = $urandom_range(0, 1);
        rerun_at = run_at + run_len + $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          back = 8'($urandom);
          if (back == level_q) back = ~back;
          if (shape < 6) begin
            // well-formed line: one run, sometimes a second one after a gap
            red = ((k >= run_at && k < run_at + run_len) ||
                   (rerun && k >= rerun_at && k < rerun_at + run_len)) ? level_q : back;
          end else if (shape < 8) begin
            red = back;
          end else begin
            red = $urandom_range(0, 1) ? level_q : 8'($urandom);
          end
          px.red_value = red;
          px.line_last = (k == len - 1);
          case ($urandom_range(0, 7))
            0:       px.eye_angle = 16'h7FFF;
            1:       px.eye_angle = 16'h8000;
            default: px.eye_angle = 16'($urandom);
          endcase
          px.eye_tag = 1'($urandom);
          send_pixel(px, 1'b0, '0);
        end
        items += len;
        if ($urandom_range(0, 11) == 0) hold_until_drained(1'b0);
      end
    end

    hold_until_drained(1'b1);
    if (mismatches == 0) begin
      $display("[red_run_bearing_tracker_unit] OK");
    end else begin
      $display("[red_run_bearing_tracker_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/rrbt_pkg.sv
rtl/core/rrbt_front.sv
rtl/core/rrbt_queue.sv
rtl/core/rrbt_back.sv
rtl/core/red_run_bearing_tracker_unit.sv
tb/red_run_bearing_tracker_unit_tb.sv
